/* src/rkwd_pkg.sv */
// Package for the rolling key word descrambler.
// Item types, register map codes and mode codes; no dependencies.
package rkwd_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 8;
    localparam int MODE_W = 3;
    localparam int ADDR_W = 4;

    localparam logic [WORD_W-1:0] KEY_STEP = 32'h0765_4321;

    // Scramble modes
    localparam logic [MODE_W-1:0] MODE_PLAIN    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_NZ_STEP  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INV_STEP = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INV_LEN  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ROT_LEN  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ROT_STEP = 3'd5;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_INIT   = 2'd1;
    localparam logic [1:0] REG_LENGTH = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic              first_word;
        logic              final_word;
    } src_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] plain_word;
        logic              final_out;
    } res_item_t;

    typedef struct packed {
        logic [MODE_W-1:0] scramble_mode;
        logic [WORD_W-1:0] initial_key;
        logic [WORD_W-1:0] stream_length;
    } cfg_t;

endpackage

/* src/rolling_key_word_descrambler.sv */
// Top level of the rolling key word descrambler.
// Depends on rkwd_pkg, rkwd_cfg and rkwd_key.

// The block takes one 32-bit word per cycle while src_stall is low and returns
// one descrambled word per input item, in order. An accepted item is held in
// the input register, and the key step (reload, group reset or rotate, one
// 32-bit add, XOR) runs between that register and the result register, which
// drives res_valid. The running key and the 8-bit word counter update in the
// same cycle, which is what sets the rate of one item per clock while neither
// side stalls. Either side may stall at any time; the input register keeps
// accepting while the result register is drained. Registers are to be written
// through the APB-style port only while the block is idle; the user must keep
// to this, as the block itself does not enforce it: mode at 0x0, initial key
// at 0x4, stream length at 0x8.
module rolling_key_word_descrambler (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rkwd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // scrambled items
    input  logic                         src_valid,
    output logic                         src_stall,
    input  rkwd_pkg::src_item_t          src_item,
    // descrambled items
    output logic                         res_valid,
    input  logic                         res_stall,
    output rkwd_pkg::res_item_t          res_item
);
    import rkwd_pkg::*;

    cfg_t              cfg;

    // input register
    logic              in_valid_reg;
    src_item_t         in_item_reg;

    // running state
    logic [WORD_W-1:0] key_reg;
    logic [WORD_W-1:0] key_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    // result register
    logic              res_valid_reg;
    res_item_t         res_item_reg;
    res_item_t         res_item_next;

    logic              res_free;   // result register can take a new item
    logic              advance;    // input register moves into result register
    logic              src_take;

    rkwd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rkwd_key u_key (
        .cfg     (cfg),
        .key_cur (key_reg),
        .cnt_cur (cnt_reg),
        .item    (in_item_reg),
        .key_new (key_next),
        .cnt_new (cnt_next),
        .res     (res_item_next)
    );

    assign res_free  = !res_valid_reg || !res_stall;
    assign advance   = in_valid_reg && res_free;
    // input register is free when empty or moving on this cycle
    assign src_stall = in_valid_reg && !res_free;
    assign src_take  = src_valid && !src_stall;

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            key_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (src_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                res_valid_reg <= 1'b1;
                key_reg       <= key_next;
                cnt_reg       <= cnt_next;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (src_take)
            in_item_reg <= src_item;
        if (advance)
            res_item_reg <= res_item_next;
    end

`ifndef NO_ASSERTIONS
    // an accepted item always lands in the input register
    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        src_take |=> in_valid_reg)
        else $error("accepted item lost at input register");

    // a processed item always shows on the result side
    a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("processed item did not reach result register");

    // a first word restarts the counter, so the next index is one
    a_first_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_item_reg.first_word) |=> (cnt_reg == 8'd1))
        else $error("counter not restarted by first word");

    // plain mode never touches the key unless a first word reloads it
    a_plain_key: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_item_reg.first_word && cfg.scramble_mode == MODE_PLAIN)
        |=> $stable(key_reg))
        else $error("key changed in plain mode");
`endif

endmodule

/* src/rkwd_cfg.sv */
// APB-style register file for the descrambler: mode, initial key, length.
// Depends on rkwd_pkg.
module rkwd_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rkwd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output rkwd_pkg::cfg_t               cfg
);
    import rkwd_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MODE:   cfg_reg.scramble_mode <= pwdata[MODE_W-1:0];
                REG_INIT:   cfg_reg.initial_key   <= pwdata;
                REG_LENGTH: cfg_reg.stream_length <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_MODE:   prdata = {{(32-MODE_W){1'b0}}, cfg_reg.scramble_mode};
            REG_INIT:   prdata = cfg_reg.initial_key;
            REG_LENGTH: prdata = cfg_reg.stream_length;
            default:    prdata = 32'h0;
        endcase
    end

endmodule

/* src/rkwd_key.sv */
// Key step for one word: reload, group reset or rotate, add, then XOR (with the byte-swapped word in rotate modes).
// Depends on rkwd_pkg.
module rkwd_key (
    input  rkwd_pkg::cfg_t                 cfg,
    input  logic [rkwd_pkg::WORD_W-1:0]    key_cur,
    input  logic [rkwd_pkg::CNT_W-1:0]     cnt_cur,
    input  rkwd_pkg::src_item_t            item,
    output logic [rkwd_pkg::WORD_W-1:0]    key_new,
    output logic [rkwd_pkg::CNT_W-1:0]     cnt_new,
    output rkwd_pkg::res_item_t            res
);
    import rkwd_pkg::*;

    logic [WORD_W-1:0] key;
    logic [CNT_W-1:0]  idx;
    logic [WORD_W-1:0] key_grp;
    logic [WORD_W-1:0] key_rot;
    logic [WORD_W-1:0] swapped;
    logic              grp_start;

    // first_word reloads before the word is processed
    assign key = item.first_word ? cfg.initial_key : key_cur;
    assign idx = item.first_word ? '0 : cnt_cur;

    assign grp_start = (idx == '0);
    assign key_rot   = (idx[1:0] != 2'd0) ? {key[WORD_W-2:0], key[WORD_W-1]} : key;
    assign swapped   = {item.data_word[7:0], item.data_word[15:8],
                        item.data_word[23:16], item.data_word[31:24]};
    assign cnt_new   = idx + 1'b1;

    always_comb
    begin
        key_grp = key;
        key_new = key;
        res.plain_word = item.data_word;
        case (cfg.scramble_mode)
            MODE_NZ_STEP:
            begin
                if (grp_start)
                    key_grp = {{(WORD_W-1){1'b0}}, (key != '0)};
                key_new = key_grp + KEY_STEP;
                res.plain_word = item.data_word ^ key_new;
            end
            MODE_INV_STEP:
            begin
                if (grp_start)
                    key_grp = ~key;
                key_new = key_grp + KEY_STEP;
                res.plain_word = item.data_word ^ key_new;
            end
            MODE_INV_LEN:
            begin
                if (grp_start)
                    key_grp = ~key;
                key_new = key_grp + cfg.stream_length;
                res.plain_word = item.data_word ^ key_new;
            end
            MODE_ROT_LEN:
            begin
                key_new = cfg.stream_length + ~key_rot;
                res.plain_word = swapped ^ key_new;
            end
            MODE_ROT_STEP:
            begin
                key_new = KEY_STEP + ~key_rot;
                res.plain_word = swapped ^ key_new;
            end
            default:
            begin
                // plain and unknown modes: pass through, key held
                key_new = key;
            end
        endcase
        res.final_out = item.final_word;
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for rolling_key_word_descrambler.
// Needs rkwd_pkg and the block RTL; drives the APB port and both item channels.
module testbench;
    import rkwd_pkg::*;

    localparam int GAP_MAX      = 15;
    localparam int IDLE_LIMIT   = 2000;
    localparam int FLUSH_CYCLES = 10;
    localparam int RANDOM_ITEMS = 1700;

    // codes with no defined behavior: treated as plain pass-through
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    logic      src_valid = 1'b0;
    logic      src_stall;
    src_item_t src_item = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res_item;

    // register copies and key state of the prediction
    logic [MODE_W-1:0] mode_now = MODE_PLAIN;
    logic [WORD_W-1:0] init_key_now = '0;
    logic [WORD_W-1:0] length_now = '0;
    logic [WORD_W-1:0] key_now = '0;
    logic [CNT_W-1:0]  word_idx = '0;

    res_item_t pending_words[$];
    int        err_count = 0;
    int        random_sent = 0;
    bit        no_idle = 1'b0;
    int        stall_left = 0;
    int        idle_cycles = 0;
    res_item_t want_res;

    rolling_key_word_descrambler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    always #6 clk = ~clk;

    // Expected result of one word; advances the predicted key and counter.
    function automatic res_item_t descramble_word(input src_item_t it);
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] swapped;
        logic [CNT_W-1:0]  idx;
        res_item_t         r;
        if (it.first_word)
        begin
            key_now  = init_key_now;
            word_idx = '0;
        end
        key          = key_now;
        idx          = word_idx;
        swapped      = {it.data_word[7:0], it.data_word[15:8],
                        it.data_word[23:16], it.data_word[31:24]};
        r.plain_word = it.data_word;
        r.final_out  = it.final_word;
        case (mode_now)
            MODE_NZ_STEP:
            begin
                // group start collapses the key to a zero/nonzero flag
                if (idx == '0)
                    key = (key != '0) ? 32'd1 : 32'd0;
                key          = key + KEY_STEP;
                r.plain_word = it.data_word ^ key;
            end
            MODE_INV_STEP:
            begin
                if (idx == '0)
                    key = ~key;
                key          = key + KEY_STEP;
                r.plain_word = it.data_word ^ key;
            end
            MODE_INV_LEN:
            begin
                if (idx == '0)
                    key = ~key;
                key          = key + length_now;
                r.plain_word = it.data_word ^ key;
            end
            MODE_ROT_LEN:
            begin
                if (idx[1:0] != 2'd0)
                    key = {key[WORD_W-2:0], key[WORD_W-1]};
                key          = length_now + ~key;
                r.plain_word = swapped ^ key;
            end
            MODE_ROT_STEP:
            begin
                if (idx[1:0] != 2'd0)
                    key = {key[WORD_W-2:0], key[WORD_W-1]};
                key          = KEY_STEP + ~key;
                r.plain_word = swapped ^ key;
            end
            default:
            begin
                // plain and spare codes: word and key untouched
            end
        endcase
        key_now  = key;
        word_idx = idx + 1'b1;
        return r;
    endfunction

    // One APB transfer; returns at the access edge with the bus released.
    task automatic apb_xfer(input logic wr, input logic [1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write a register, read it back, and update the register copy.
    task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] rd;
        logic [31:0] stored;
        apb_xfer(1'b1, idx, val, rd);
        stored = (idx == REG_MODE) ? {29'd0, val[MODE_W-1:0]} : val;
        case (idx)
            REG_MODE:   mode_now     = val[MODE_W-1:0];
            REG_INIT:   init_key_now = val;
            REG_LENGTH: length_now   = val;
            default:    ;
        endcase
        @(posedge clk);
        apb_xfer(1'b0, idx, '0, rd);
        if (rd !== stored)
        begin
            $display("%0t: readback of register %0d: expected %h, actual %h",
                     $time, idx, stored, rd);
            err_count++;
        end
        @(posedge clk);
    endtask

    task automatic set_config(input logic [MODE_W-1:0] mode, input logic [31:0] key,
                              input logic [31:0] len);
        set_reg(REG_MODE, {29'd0, mode});
        set_reg(REG_INIT, key);
        set_reg(REG_LENGTH, len);
    endtask

    // Offer one item after a random gap; valid stays high when the gap is zero.
    task automatic send_word(input logic [31:0] data, input logic first,
                             input logic last);
        int        gap;
        src_item_t it;
        gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.data_word  = data;
        it.first_word = first;
        it.final_word = last;
        src_item  <= it;
        src_valid <= 1'b1;
        do
            @(posedge clk);
        while (src_stall);
        pending_words.push_back(descramble_word(it));
    endtask

    // Drop valid and wait for every predicted item to come back.
    task automatic drain;
        src_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // A stream of random words; noisy streams scatter the marker bits.
    task automatic send_stream(input int len, input bit noisy);
        logic [31:0] data;
        logic        first;
        logic        last;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 15))
                0:       data = 32'h0000_0000;
                1:       data = 32'hFFFF_FFFF;
                default: data = $urandom();
            endcase
            first = noisy ? ($urandom_range(0, 7) == 0) : (i == 0);
            last  = noisy ? ($urandom_range(0, 7) == 0) : (i == len - 1);
            send_word(data, first, last);
            random_sent++;
        end
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Words before any stream start run from the reset key and counter.
    task automatic test_pre_stream;
        set_reg(REG_MODE, {29'd0, MODE_INV_STEP});
        send_word(32'h0000_0000, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(32'hA5A5_5A5A, 1'b0, 1'b1);
        drain();
    endtask

    // Every mode code, extreme key and length, extreme words.
    task automatic test_each_mode;
        logic [MODE_W-1:0] mode_list [8];
        mode_list = '{MODE_PLAIN, MODE_NZ_STEP, MODE_INV_STEP, MODE_INV_LEN,
                      MODE_ROT_LEN, MODE_ROT_STEP, MODE_SPARE_LO, MODE_SPARE_HI};
        for (int m = 0; m < 8; m++)
        begin
            if (m % 2 == 1)
                set_config(mode_list[m], 32'h0000_0000, 32'hFFFF_FFFF);
            else
                set_config(mode_list[m], 32'hFFFF_FFFF, 32'h0000_0000);
            send_word(32'h0000_0000, 1'b1, 1'b0);
            send_word(32'hFFFF_FFFF, 1'b0, 1'b1);
            drain();
        end
    endtask

    // Registers rewritten between words of one stream; key and counter carry on.
    task automatic test_mid_stream_change;
        set_config(MODE_NZ_STEP, 32'h1234_5678, 32'h0000_0100);
        send_word(32'hDEAD_BEEF, 1'b1, 1'b0);
        send_word(32'h0F0F_0F0F, 1'b0, 1'b0);
        drain();
        set_reg(REG_MODE, {29'd0, MODE_ROT_LEN});
        set_reg(REG_LENGTH, 32'h8000_0000);
        send_word(32'h1357_9BDF, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFE, 1'b0, 1'b1);
        drain();
    endtask

    // Long streams in the group reset and rotate modes cross the counter wrap.
    task automatic test_counter_wrap;
        set_config(MODE_INV_LEN, $urandom(), $urandom());
        send_stream(300, 1'b0);
        drain();
        set_config(MODE_ROT_STEP, $urandom(), $urandom());
        send_stream(260, 1'b0);
        drain();
    endtask

    // Random settings per phase; mostly well-formed streams, some noise.
    task automatic test_random_streams;
        int phase_start;
        int len;
        while (random_sent < RANDOM_ITEMS)
        begin
            drain();
            no_idle = ($urandom_range(0, 3) == 0);
            set_config(MODE_W'($urandom_range(0, 7)), pick_word(), pick_word());
            phase_start = random_sent;
            while (random_sent - phase_start < 150)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(250, 300)
                                                  : $urandom_range(1, 20);
                send_stream(len, $urandom_range(0, 9) == 0);
            end
        end
        drain();
        no_idle = 1'b0;
    endtask

    // Result checker and receiver stall pattern.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (pending_words.size() == 0)
                begin
                    $display("%0t: item with nothing expected: plain_word %h final_out %b",
                             $time, res_item.plain_word, res_item.final_out);
                    err_count++;
                end
                else
                begin
                    want_res = pending_words.pop_front();
                    if (res_item.plain_word !== want_res.plain_word)
                    begin
                        $display("%0t: plain_word expected %h, actual %h",
                                 $time, want_res.plain_word, res_item.plain_word);
                        err_count++;
                    end
                    if (res_item.final_out !== want_res.final_out)
                    begin
                        $display("%0t: final_out expected %b, actual %b",
                                 $time, want_res.final_out, res_item.final_out);
                        err_count++;
                    end
                end
                stall_left = no_idle ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (stall_left > 0)
            begin
                res_stall <= 1'b1;
                stall_left--;
            end
            else
                res_stall <= 1'b0;
        end
    end

    // Watchdog: any accepted item or bus access counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((src_valid && !src_stall) || (res_valid && !res_stall) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_pre_stream();
        test_each_mode();
        test_mid_stream_change();
        test_counter_wrap();
        test_random_streams();
        drain();
        repeat (FLUSH_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
src/rkwd_pkg.sv
src/rkwd_cfg.sv
src/rkwd_key.sv
src/rolling_key_word_descrambler.sv
dv/testbench.sv
